// ===== design/xmcr_pkg.sv =====
// shared types and constants for the xmodem crc receiver
package xmcr_pkg;
	localparam int PACKET_BYTES_DEF = 128;
	localparam int PAGE_BYTES_DEF = 512;
	localparam int CFG_W = 24;

	localparam logic [1:0] FUNC_START = 2'd0;
	localparam logic [1:0] FUNC_BYTE = 2'd1;
	localparam logic [1:0] FUNC_TICK = 2'd2;

	localparam logic [1:0] REG_BASE = 2'd0;
	localparam logic [1:0] REG_TIMEOUT = 2'd1;
	localparam logic [1:0] REG_NAKLIM = 2'd2;

	localparam logic [7:0] SOH_BYTE = 8'h01;
	localparam logic [7:0] EOT_BYTE = 8'h04;
	localparam logic [7:0] CAN_BYTE = 8'h18;
	localparam logic [7:0] ACK_BYTE = 8'h06;
	localparam logic [7:0] NAK_BYTE = 8'h15;
	localparam logic [7:0] C_BYTE = 8'h43;
	localparam logic [7:0] DOT_BYTE = 8'h2e;

	localparam logic [2:0] EV_NONE = 3'd0;
	localparam logic [2:0] EV_CANCEL = 3'd1;
	localparam logic [2:0] EV_DONE = 3'd2;
	localparam logic [2:0] EV_RETRY = 3'd3;
	localparam logic [2:0] EV_TIMEOUT = 3'd4;

	// command from front to back: a single result, or a page flush
	typedef struct packed {
		logic flush;
		logic tx_valid;
		logic [7:0] tx_byte;
		logic erase;
		logic [23:0] addr;
		logic [2:0] ev;
	} cmd_t;

	function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] v;
		v = c ^ {b, 8'h00};
		for (int i = 0; i < 8; i++)
			v = v[15] ? ((v << 1) ^ 16'h1021) : (v << 1);
		return v;
	endfunction
endpackage

// ===== design/xmcr_front.sv =====
// protocol parser: classifies requests, stores data bytes, issues commands
module xmcr_front import xmcr_pkg::*; #(
	parameter int PACKET_BYTES = PACKET_BYTES_DEF,
	parameter int PAGE_BYTES = PAGE_BYTES_DEF,
	localparam int AW = $clog2(PAGE_BYTES),
	localparam int PW = $clog2(PACKET_BYTES)
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [CFG_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] func,
	input logic [7:0] rx_byte,
	output logic cmd_valid,
	output cmd_t cmd,
	input logic cmd_full,
	input logic page_busy,
	output logic mem_we,
	output logic [AW-1:0] mem_addr,
	output logic [7:0] mem_data
);
	typedef enum logic [5:0] {
		PH_HDR = 6'b000001, PH_SEQ = 6'b000010, PH_INV = 6'b000100,
		PH_DATA = 6'b001000, PH_CRCH = 6'b010000, PH_CRCL = 6'b100000
	} phase_t;

	logic [23:0] base_q;
	logic [15:0] tmo_q;
	logic [7:0] nlim_q;
	logic active_q;
	phase_t phase_q;
	logic [7:0] seq_q;
	logic [PW-1:0] pos_q;
	logic [15:0] crc_q;
	logic [7:0] rcrch_q;
	logic [7:0] nak_q;
	logic [15:0] pkt_q;
	logic [23:0] waddr_q;
	logic [15:0] idle_q;

	logic acc;
	logic [8:0] nak_next;
	logic [16:0] idle_next;
	logic [1:0] slot;
	logic [15:0] pkt_inc;

	// hold requests while the command queue is full or the page is still being read out
	assign in_stall = cmd_full || page_busy;
	assign acc = in_valid && !in_stall;
	assign nak_next = {1'b0, nak_q} + 9'd1;
	assign idle_next = {1'b0, idle_q} + 17'd1;
	assign slot = 2'(seq_q - 8'd1);
	assign pkt_inc = pkt_q + 16'd1;
	assign mem_we = acc && func == FUNC_BYTE && active_q && phase_q == PH_DATA;
	assign mem_addr = {slot, pos_q};
	assign mem_data = rx_byte;

	always_comb begin
		cmd_valid = 1'b0;
		cmd = '0;
		if (acc) begin
			unique case (func)
				FUNC_START: begin
					cmd_valid = 1'b1;
					cmd.tx_valid = 1'b1;
					cmd.tx_byte = C_BYTE;
				end
				FUNC_BYTE: if (active_q) begin
					unique case (phase_q)
						PH_HDR: begin
							if (rx_byte == EOT_BYTE) begin
								cmd_valid = 1'b1;
								cmd.tx_valid = 1'b1;
								cmd.tx_byte = ACK_BYTE;
								cmd.ev = EV_DONE;
							end else if (rx_byte == CAN_BYTE) begin
								cmd_valid = 1'b1;
								cmd.ev = EV_CANCEL;
							end
						end
						PH_SEQ, PH_INV, PH_CRCL: begin
							if ((phase_q == PH_SEQ && rx_byte == seq_q) ||
									(phase_q == PH_INV && rx_byte == ~seq_q)) begin
							end else if (phase_q == PH_SEQ && rx_byte == 8'(seq_q - 8'd1)) begin
								cmd_valid = 1'b1;
								cmd.tx_valid = 1'b1;
								cmd.tx_byte = ACK_BYTE;
							end else if (phase_q == PH_CRCL && {rcrch_q, rx_byte} == crc_q) begin
								cmd_valid = 1'b1;
								cmd.tx_valid = 1'b1;
								cmd.tx_byte = ACK_BYTE;
								cmd.flush = slot == 2'd3;
								cmd.erase = pkt_inc[2:0] == 3'd4;
								cmd.addr = waddr_q;
							end else begin
								cmd_valid = 1'b1;
								cmd.tx_valid = 1'b1;
								cmd.tx_byte = NAK_BYTE;
								cmd.ev = (nak_next > {1'b0, nlim_q}) ? EV_RETRY : EV_NONE;
							end
						end
						default: ;
					endcase
				end
				FUNC_TICK: if (active_q && idle_next > {1'b0, tmo_q}) begin
					cmd_valid = 1'b1;
					cmd.ev = EV_TIMEOUT;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			tmo_q <= 16'd10000;
			nlim_q <= 8'd20;
			active_q <= 1'b0;
			phase_q <= PH_HDR;
			seq_q <= 8'd1;
			pos_q <= '0;
			crc_q <= '0;
			rcrch_q <= '0;
			nak_q <= '0;
			pkt_q <= '0;
			waddr_q <= '0;
			idle_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_BASE: base_q <= cfg_data;
					REG_TIMEOUT: tmo_q <= cfg_data[15:0];
					REG_NAKLIM: nlim_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (acc) begin
				unique case (func)
					FUNC_START: begin
						active_q <= 1'b1;
						phase_q <= PH_HDR;
						seq_q <= 8'd1;
						pos_q <= '0;
						crc_q <= '0;
						nak_q <= '0;
						pkt_q <= '0;
						waddr_q <= base_q;
						idle_q <= '0;
					end
					FUNC_BYTE: if (active_q) begin
						idle_q <= '0;
						unique case (phase_q)
							PH_HDR: begin
								if (rx_byte == SOH_BYTE) begin
									pos_q <= '0;
									crc_q <= '0;
									phase_q <= PH_SEQ;
								end else if (rx_byte == EOT_BYTE || rx_byte == CAN_BYTE)
									active_q <= 1'b0;
							end
							PH_DATA: begin
								crc_q <= crc_step(crc_q, rx_byte);
								pos_q <= pos_q + 1'b1;
								if (&pos_q)
									phase_q <= PH_CRCH;
							end
							PH_CRCH: begin
								rcrch_q <= rx_byte;
								phase_q <= PH_CRCL;
							end
							default: begin
								if (phase_q == PH_SEQ && rx_byte == seq_q)
									phase_q <= PH_INV;
								else if (phase_q == PH_INV && rx_byte == ~seq_q) begin
									pos_q <= '0;
									crc_q <= '0;
									phase_q <= PH_DATA;
								end else if (phase_q == PH_SEQ && rx_byte == 8'(seq_q - 8'd1))
									phase_q <= PH_HDR;
								else if (phase_q == PH_CRCL && {rcrch_q, rx_byte} == crc_q) begin
									nak_q <= '0;
									pkt_q <= pkt_inc;
									seq_q <= seq_q + 8'd1;
									if (slot == 2'd3)
										waddr_q <= waddr_q + 24'(PAGE_BYTES);
									phase_q <= PH_HDR;
								end else begin
									nak_q <= nak_next[8] ? 8'hff : nak_next[7:0];
									phase_q <= PH_HDR;
									if (nak_next > {1'b0, nlim_q})
										active_q <= 1'b0;
								end
							end
						endcase
					end
					FUNC_TICK: if (active_q) begin
						idle_q <= idle_next[16] ? 16'hffff : idle_next[15:0];
						if (idle_next > {1'b0, tmo_q}) begin
							active_q <= 1'b0;
							phase_q <= PH_HDR;
						end
					end
					default: ;
				endcase
			end
		end
	end
endmodule

// ===== design/xmcr_back.sv =====
// result sequencer: pops commands, expands flushes into page writes
module xmcr_back import xmcr_pkg::*; #(
	parameter int PAGE_BYTES = PAGE_BYTES_DEF,
	localparam int AW = $clog2(PAGE_BYTES),
	localparam int WW = AW - 3
) (
	input logic clk,
	input logic arst_n,
	input logic mem_we,
	input logic [AW-1:0] mem_addr,
	input logic [7:0] mem_data,
	input logic cmd_valid,
	input cmd_t cmd,
	output logic cmd_full,
	output logic page_busy,
	output logic valid,
	input logic stall,
	output logic tx_valid,
	output logic [7:0] tx_byte,
	output logic erase_sector,
	output logic write_valid,
	output logic [23:0] flash_address,
	output logic [63:0] write_word,
	output logic [2:0] event_res,
	output logic last
);
	logic [63:0] mem_q [PAGE_BYTES/8];
	logic [7:0] lane_we;
	logic [63:0] rd_q;

	logic [1:0] cnt_q;
	cmd_t fifo_q [2];
	logic rp_q, wp_q;
	cmd_t cur_q;
	logic busy_q;
	logic [WW-1:0] w_q;
	logic rd_pend_q;
	logic out_v_q;
	logic [WW-1:0] ow_q;
	logic ofl_q;
	cmd_t oc_q;
	logic page_busy_q;

	logic pop, push, out_free, launch;

	always_comb
		for (int i = 0; i < 8; i++)
			lane_we[i] = mem_we && mem_addr[2:0] == 3'(i);

	always_ff @(posedge clk) begin
		for (int i = 0; i < 8; i++)
			if (lane_we[i])
				mem_q[mem_addr[AW-1:3]][i*8 +: 8] <= mem_data;
		if (launch)
			rd_q <= mem_q[w_q];
	end

	assign cmd_full = cnt_q == 2'd2;
	assign page_busy = page_busy_q;
	assign push = cmd_valid;
	assign out_free = !out_v_q || !stall;
	// one word in flight: launch read, then present
	assign launch = busy_q && !rd_pend_q && out_free;
	assign pop = !busy_q && cnt_q != 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rp_q <= 1'b0;
			wp_q <= 1'b0;
			busy_q <= 1'b0;
			w_q <= '0;
			rd_pend_q <= 1'b0;
			out_v_q <= 1'b0;
			ow_q <= '0;
			ofl_q <= 1'b0;
			oc_q <= '0;
			cur_q <= '0;
			page_busy_q <= 1'b0;
		end else begin
			if (push) begin
				fifo_q[wp_q] <= cmd;
				wp_q <= !wp_q;
				if (cmd.flush)
					page_busy_q <= 1'b1;
			end
			if (pop) begin
				cur_q <= fifo_q[rp_q];
				rp_q <= !rp_q;
				busy_q <= 1'b1;
				w_q <= '0;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
			if (out_v_q && !stall)
				out_v_q <= 1'b0;
			if (launch)
				rd_pend_q <= 1'b1;
			if (rd_pend_q && out_free) begin
				rd_pend_q <= 1'b0;
				out_v_q <= 1'b1;
				oc_q <= cur_q;
				ow_q <= w_q;
				ofl_q <= cur_q.flush;
				if (cur_q.flush && &w_q)
					page_busy_q <= 1'b0;
				if (!cur_q.flush || &w_q)
					busy_q <= 1'b0;
				else
					w_q <= w_q + 1'b1;
			end
		end
	end

	always_comb begin
		valid = out_v_q;
		tx_valid = oc_q.tx_valid;
		tx_byte = oc_q.tx_byte;
		erase_sector = 1'b0;
		write_valid = 1'b0;
		flash_address = '0;
		write_word = '0;
		event_res = oc_q.ev;
		last = 1'b1;
		if (ofl_q) begin
			write_valid = 1'b1;
			write_word = rd_q;
			flash_address = oc_q.addr + 24'({ow_q, 3'b000});
			last = &ow_q;
			tx_valid = ow_q == '0 || &ow_q;
			tx_byte = ow_q == '0 ? ACK_BYTE : DOT_BYTE;
			erase_sector = ow_q == '0 && oc_q.erase;
		end
	end
endmodule

// ===== design/xmodem_crc_receiver_unit.sv =====
// top level of the xmodem crc receiver
//  channel  | handshake        | payload
//  in       | in_valid/in_stall| func, rx_byte
//  out      | valid/stall      | tx_valid .. last
//  cfg      | cfg_we           | cfg_index, cfg_data
// a request is parsed when accepted; a single result is queued, then read out and shown
// a page flush gives 64 results, each a page memory read then a present
// input stalls during a flush, until its last result is presented
// reset clears control state; page memory is not cleared
// a two-entry command queue lets input run while results are stalled
module xmodem_crc_receiver_unit import xmcr_pkg::*; #(
	parameter int PACKET_BYTES = PACKET_BYTES_DEF,
	parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [CFG_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] func,
	input logic [7:0] rx_byte,
	output logic valid,
	input logic stall,
	output logic tx_valid,
	output logic [7:0] tx_byte,
	output logic erase_sector,
	output logic write_valid,
	output logic [23:0] flash_address,
	output logic [63:0] write_word,
	output logic [2:0] event_res,
	output logic last
);
	localparam int AW = $clog2(PAGE_BYTES);
	logic cmd_valid, cmd_full, mem_we, page_busy;
	cmd_t cmd;
	logic [AW-1:0] mem_addr;
	logic [7:0] mem_data;

	xmcr_front #(.PACKET_BYTES(PACKET_BYTES), .PAGE_BYTES(PAGE_BYTES)) u_front (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .in_valid, .in_stall,
		.func, .rx_byte, .cmd_valid, .cmd, .cmd_full, .page_busy, .mem_we, .mem_addr,
		.mem_data
	);

	xmcr_back #(.PAGE_BYTES(PAGE_BYTES)) u_back (
		.clk, .arst_n, .mem_we, .mem_addr, .mem_data, .cmd_valid, .cmd, .cmd_full,
		.page_busy, .valid, .stall, .tx_valid, .tx_byte, .erase_sector, .write_valid,
		.flash_address, .write_word, .event_res, .last
	);
endmodule
